@@ rtl/core/swmf_pkg.sv @@
// Package for the sliding window median filter.
// Holds shared widths, parameter defaults and the cell flag type.
// No dependencies.
package swmf_pkg;

    localparam int MAX_WINDOW_DEF  = 15;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 4;
    localparam int TAG_W           = 4;

    // flags handed from one cell to the next
    typedef struct packed {
        logic le;   // cell holds a valid entry <= new sample
        logic sh;   // the entry being dropped sits at or left of this cell
    } t_cell_flags;

endpackage

@@ rtl/core/sliding_window_median_filter.sv @@
// Running median filter over an odd-sized sliding window of signed samples.
// Depends on swmf_pkg and swmf_chain.
//
// Usage:
//   Input channel i_valid/o_ready carries i_sample; output channel
//   o_valid/i_ready carries o_filtered_sample and o_median_valid.
//   The window is kept sorted in a row of cells: each request inserts the
//   new sample and, once the window is full, drops the oldest one with it.
//   The result is loaded into the output register in the cycle after the
//   request is accepted, and no new request is taken while one is pending:
//   the cell row update is followed by the median tap select into the output register.
//   Until window_size requests have arrived, the sample is passed through
//   with o_median_valid low; after that each result is the median.
//   APB register 0 (address 0): window_size, 4 bits, reset 5. Zero, even or
//   too large values are ignored; an accepted write restarts the fill.
//   Reset (i_rst_n low, synchronous) empties the window and the output.
//   When the receiver stalls, the result holds in the output register and
//   o_ready stays low until it is taken.
module sliding_window_median_filter import swmf_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_filtered_sample,
    output logic                          o_median_valid,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic        [2:0]             paddr,
    input  logic        [31:0]            pwdata,
    output logic        [31:0]            prdata,
    output logic                          pready
);

    localparam logic             REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_W-1:0] CFG_RESET_SIZE  = CFG_W'(5);

    logic                          r_pend;
    logic signed [SAMPLE_BITS-1:0] r_pend_sample;
    logic                          r_pend_filled;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_mvalid;
    logic        [CFG_W-1:0]       r_size;
    logic        [TAG_W-1:0]       r_pos, n_pos;
    logic                          r_filled, n_filled;

    logic                          w_in_acc;
    logic                          w_cfg_wr;
    logic                          w_cfg_ok;
    logic        [CFG_W-1:0]       w_cfg_val;
    logic        [TAG_W-1:0]       w_pos_inc;
    logic signed [SAMPLE_BITS-1:0] w_median;
    logic        [MAX_WINDOW-1:0]  w_valid_vec;

    assign pready    = 1'b1;
    assign w_cfg_val = pwdata[CFG_W-1:0];
    assign w_cfg_ok  = w_cfg_val[0] && (int'(w_cfg_val) <= MAX_WINDOW);
    assign w_cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE) && w_cfg_ok;
    assign prdata    = (paddr[2] == REG_WINDOW_SIZE) ? {{(32-CFG_W){1'b0}}, r_size} : '0;

    assign o_ready   = !r_pend && (!r_out_valid || i_ready);
    assign w_in_acc  = i_valid && o_ready;

    assign w_pos_inc = r_pos + TAG_W'(1);

    always_comb begin
        n_pos    = w_pos_inc;
        n_filled = r_filled;
        if ({{(TAG_W){1'b0}}, w_pos_inc} >= {{(TAG_W){1'b0}}, TAG_W'(r_size)}) begin
            n_pos    = '0;
            n_filled = 1'b1;
        end
    end

    swmf_chain #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_cfg_wr),
        .i_load      (w_in_acc),
        .i_sample    (i_sample),
        .i_tag       (r_pos),
        .i_half      (r_size >> 1),
        .o_median    (w_median),
        .o_valid_vec (w_valid_vec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= CFG_RESET_SIZE;
            r_pos       <= '0;
            r_filled    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_size   <= w_cfg_val;
                r_pos    <= '0;
                r_filled <= 1'b0;
            end else if (w_in_acc) begin
                r_pos    <= n_pos;
                r_filled <= n_filled;
            end
            r_pend <= w_in_acc;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend_sample <= i_sample;
            r_pend_filled <= n_filled;
        end
        if (r_pend) begin
            r_out_sample <= r_pend_filled ? w_median : r_pend_sample;
            r_out_mvalid <= r_pend_filled;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_median_valid    = r_out_mvalid;

    a_pend_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_out_valid)
        else $error("pending request did not reach the output register");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled |-> ($countones(w_valid_vec) == int'(r_size)))
        else $error("full window does not hold window_size entries");

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_filled |-> ($countones(w_valid_vec) == int'(r_pos)))
        else $error("filling window entry count does not match position");

endmodule

@@ rtl/core/swmf_cell.sv @@
// One cell of the sorted insertion chain: holds a sample, its slot tag and a valid bit.
// Depends on swmf_pkg.
module swmf_cell import swmf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic        [TAG_W-1:0]       i_tag,
    input  logic signed [SAMPLE_BITS-1:0] i_left_val,
    input  logic        [TAG_W-1:0]       i_left_tag,
    input  logic                          i_left_valid,
    input  t_cell_flags                   i_left_flags,
    input  logic signed [SAMPLE_BITS-1:0] i_right_val,
    input  logic        [TAG_W-1:0]       i_right_tag,
    input  logic                          i_right_le,
    output logic signed [SAMPLE_BITS-1:0] o_val,
    output logic        [TAG_W-1:0]       o_tag,
    output logic                          o_valid,
    output t_cell_flags                   o_flags
);

    logic signed [SAMPLE_BITS-1:0] r_val, n_val;
    logic        [TAG_W-1:0]       r_tag, n_tag;
    logic                          r_valid, n_valid;
    logic                          w_del;
    logic                          w_le;
    logic                          w_sh;

    assign w_del = r_valid && (r_tag == i_tag);
    assign w_le  = r_valid && (r_val <= i_sample);
    assign w_sh  = i_left_flags.sh | w_del;

    always_comb begin
        // kept entry for this position: self, or right neighbor once shifted
        // kept entry for the position to the left: left neighbor, or self once shifted
        n_val   = r_val;
        n_tag   = r_tag;
        n_valid = r_valid;
        if (w_sh ? i_right_le : w_le) begin
            n_val   = w_sh ? i_right_val : r_val;
            n_tag   = w_sh ? i_right_tag : r_tag;
            n_valid = 1'b1;
        end else if (i_left_flags.sh ? w_le : i_left_flags.le) begin
            n_val   = i_sample;
            n_tag   = i_tag;
            n_valid = 1'b1;
        end else begin
            n_val   = i_left_flags.sh ? r_val   : i_left_val;
            n_tag   = i_left_flags.sh ? r_tag   : i_left_tag;
            n_valid = i_left_flags.sh ? r_valid : i_left_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !i_clear) begin
            r_val <= n_val;
            r_tag <= n_tag;
        end
    end

    assign o_val      = r_val;
    assign o_tag      = r_tag;
    assign o_valid    = r_valid;
    assign o_flags.le = w_le;
    assign o_flags.sh = w_sh;

endmodule

@@ rtl/core/swmf_chain.sv @@
// Row of sorted insertion cells with the median tap select.
// Depends on swmf_pkg and swmf_cell.
module swmf_chain import swmf_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_load,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic        [TAG_W-1:0]       i_tag,
    input  logic        [CFG_W-1:0]       i_half,
    output logic signed [SAMPLE_BITS-1:0] o_median,
    output logic        [MAX_WINDOW-1:0]  o_valid_vec
);

    // index 0 and MAX_WINDOW+1 are the chain ends
    logic signed [SAMPLE_BITS-1:0] w_val   [MAX_WINDOW+2];
    logic        [TAG_W-1:0]       w_tag   [MAX_WINDOW+2];
    logic                          w_valid [MAX_WINDOW+2];
    t_cell_flags                   w_flags [MAX_WINDOW+2];

    assign w_val[0]              = '0;
    assign w_tag[0]              = '0;
    assign w_valid[0]            = 1'b0;
    assign w_flags[0]            = '{le: 1'b1, sh: 1'b0};
    assign w_val[MAX_WINDOW+1]   = '0;
    assign w_tag[MAX_WINDOW+1]   = '0;
    assign w_valid[MAX_WINDOW+1] = 1'b0;
    assign w_flags[MAX_WINDOW+1] = '{le: 1'b0, sh: 1'b0};

    for (genvar g = 1; g <= MAX_WINDOW; g++) begin : g_cell
        swmf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_clear      (i_clear),
            .i_load       (i_load),
            .i_sample     (i_sample),
            .i_tag        (i_tag),
            .i_left_val   (w_val[g-1]),
            .i_left_tag   (w_tag[g-1]),
            .i_left_valid (w_valid[g-1]),
            .i_left_flags (w_flags[g-1]),
            .i_right_val  (w_val[g+1]),
            .i_right_tag  (w_tag[g+1]),
            .i_right_le   (w_flags[g+1].le),
            .o_val        (w_val[g]),
            .o_tag        (w_tag[g]),
            .o_valid      (w_valid[g]),
            .o_flags      (w_flags[g])
        );
        assign o_valid_vec[g-1] = w_valid[g];
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (i == int'(i_half)) begin
                o_median = w_val[i+1];
            end
        end
    end

    for (genvar g = 1; g < MAX_WINDOW; g++) begin : g_chk
        a_sorted_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_valid[g+1] |-> (w_valid[g] && (w_val[g] <= w_val[g+1])))
            else $error("chain entries out of order or valid bits not a prefix");
    end

endmodule
